### rtl/indexed_min_heap_queue_macros.svh
// Assertion macros used by the sequencer of the indexed min-heap queue RTL.
`ifndef INDEXED_MIN_HEAP_QUEUE_MACROS_SVH
`define INDEXED_MIN_HEAP_QUEUE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define IMHQ_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("Heap queue assertion failed.");

// Next-cycle implication, checked outside reset.
`define IMHQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("Heap queue assertion failed.");

`endif

### rtl/imhq_pkg.sv
// Package with the types, constants and functions of the indexed min-heap queue.
package imhq_pkg;

  localparam int unsigned MaxItems = 256;
  localparam int unsigned KeyW = 32;
  localparam int unsigned IdxW = $clog2(MaxItems);
  localparam int unsigned CntW = $clog2(MaxItems + 1);
  localparam int unsigned FuncW = 3;
  localparam int unsigned StatusW = 2;
  localparam logic [KeyW-1:0] KeySign = {1'b1, {(KeyW - 1){1'b0}}};

  typedef enum logic [FuncW-1:0] {
    FuncInsert   = 3'd0,
    FuncExtract  = 3'd1,
    FuncDecrease = 3'd2,
    FuncContains = 3'd3,
    FuncIsEmpty  = 3'd4
  } func_e;

  typedef enum logic [StatusW-1:0] {
    StatusDone    = 2'd0,
    StatusIgnored = 2'd1,
    StatusEmpty   = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    StIdle,
    StDecKey,
    StExTop,
    StExLast,
    StExKey,
    StUpCheck,
    StUpPar,
    StUpCmp,
    StDnL,
    StDnLid,
    StDnLkey,
    StDnRkey,
    StDnCmp,
    StPlace,
    StResp
  } state_e;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [IdxW-1:0] pos;
  } item_word_t;

  typedef struct packed {
    logic            we;
    logic [IdxW-1:0] waddr;
    logic [IdxW-1:0] wdata;
    logic [IdxW-1:0] raddr;
  } heap_req_t;

  typedef struct packed {
    logic            we;
    logic [IdxW-1:0] waddr;
    item_word_t      wdata;
    logic [IdxW-1:0] raddr;
  } item_req_t;

  // True when item a must sit above item b; keys carry a flipped sign bit.
  function automatic logic ranks_above(logic [KeyW-1:0] ka, logic [IdxW-1:0] ia,
                                       logic [KeyW-1:0] kb, logic [IdxW-1:0] ib);
    ranks_above = (ka < kb) || ((ka == kb) && (ia < ib));
  endfunction

endpackage

### rtl/imhq_heap_mem.sv
// Heap slot memory: one write port and one registered read port.
module imhq_heap_mem (
  input  logic                             clk_i,
  input  imhq_pkg::heap_req_t              req_i,
  output logic [imhq_pkg::IdxW-1:0]        rdata_o
);

  logic [imhq_pkg::IdxW-1:0] mem [imhq_pkg::MaxItems];
  logic [imhq_pkg::IdxW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/imhq_item_mem.sv
// Per-item memory holding each item's key and heap position.
module imhq_item_mem (
  input  logic                  clk_i,
  input  imhq_pkg::item_req_t   req_i,
  output imhq_pkg::item_word_t  rdata_o
);

  imhq_pkg::item_word_t mem [imhq_pkg::MaxItems];
  imhq_pkg::item_word_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/imhq_ctrl.sv
// Sequencer of the heap queue: decode, sift up and down, presence bits and result register.
`include "indexed_min_heap_queue_macros.svh"

module imhq_ctrl (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [imhq_pkg::FuncW-1:0]          func_i,
  input  logic [imhq_pkg::IdxW-1:0]           item_id_i,
  input  logic signed [imhq_pkg::KeyW-1:0]    key_value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [imhq_pkg::StatusW-1:0]        status_o,
  output logic [imhq_pkg::CntW-1:0]           out_item_o,
  output logic                                answer_flag_o,
  output logic [imhq_pkg::CntW-1:0]           item_count_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [imhq_pkg::CntW-1:0]           capacity_in_use_i,
  output imhq_pkg::heap_req_t                 heap_req_o,
  input  logic [imhq_pkg::IdxW-1:0]           heap_rdata_i,
  output imhq_pkg::item_req_t                 item_req_o,
  input  imhq_pkg::item_word_t                item_rdata_i
);

  localparam int unsigned PosW = imhq_pkg::IdxW + 2;
  localparam int unsigned IdxW = imhq_pkg::IdxW;
  localparam int unsigned CntW = imhq_pkg::CntW;
  localparam int unsigned KeyW = imhq_pkg::KeyW;

  imhq_pkg::state_e state_q, state_d;
  logic [CntW-1:0] size_q, size_d;
  logic [CntW-1:0] cap_q, cap_d;
  logic [imhq_pkg::MaxItems-1:0] valid_q, valid_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [IdxW-1:0] jdx_q, jdx_d;
  logic [IdxW-1:0] cur_id_q, cur_id_d;
  logic [KeyW-1:0] cur_key_q, cur_key_d;
  logic [IdxW-1:0] oth_id_q, oth_id_d;
  logic [KeyW-1:0] oth_key_q, oth_key_d;
  logic [IdxW-1:0] rid_q, rid_d;
  logic [KeyW-1:0] rkey_q, rkey_d;
  logic r_ok_q, r_ok_d;
  logic [IdxW-1:0] top_q, top_d;
  imhq_pkg::status_e res_status_q, res_status_d;
  logic res_flag_q, res_flag_d;
  logic res_top_q, res_top_d;
  logic out_valid_q, out_valid_d;
  logic [imhq_pkg::StatusW-1:0] out_status_q, out_status_d;
  logic [CntW-1:0] out_item_q, out_item_d;
  logic out_flag_q, out_flag_d;
  logic [CntW-1:0] out_count_q, out_count_d;

  logic in_fire;
  logic in_range;
  logic ins_ok;
  logic dec_ok;
  logic dec_less;
  logic push;
  logic [CntW-1:0] size_m1;
  logic [IdxW-1:0] up_pos;
  logic [PosW-1:0] lpos;
  logic [PosW-1:0] rpos;
  logic [PosW-1:0] size_ext;
  logic up_move;
  logic l_above;
  logic r_above;
  logic [IdxW-1:0] best_id;
  logic [KeyW-1:0] best_key;
  logic [IdxW-1:0] best_pos;

  assign in_ready_o = (state_q == imhq_pkg::StIdle);
  assign in_fire = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign in_range = CntW'(item_id_i) < cap_q;
  assign ins_ok = in_range && !valid_q[item_id_i] && (size_q < CntW'(imhq_pkg::MaxItems));
  assign dec_ok = in_range && valid_q[item_id_i];
  assign dec_less = cur_key_q < item_rdata_i.key;
  assign push = (state_q == imhq_pkg::StResp) && (!out_valid_q || out_ready_i);
  assign size_m1 = size_q - CntW'(1);
  assign up_pos = (idx_q - IdxW'(1)) >> 1;
  assign lpos = {1'b0, idx_q, 1'b1};
  assign rpos = lpos + PosW'(1);
  assign size_ext = PosW'(size_q);
  assign up_move = imhq_pkg::ranks_above(cur_key_q, cur_id_q, item_rdata_i.key, oth_id_q);
  assign l_above = imhq_pkg::ranks_above(oth_key_q, oth_id_q, cur_key_q, cur_id_q);
  assign r_above = r_ok_q && (l_above
      ? imhq_pkg::ranks_above(rkey_q, rid_q, oth_key_q, oth_id_q)
      : imhq_pkg::ranks_above(rkey_q, rid_q, cur_key_q, cur_id_q));
  assign best_id = r_above ? rid_q : oth_id_q;
  assign best_key = r_above ? rkey_q : oth_key_q;
  assign best_pos = r_above ? rpos[IdxW-1:0] : lpos[IdxW-1:0];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      imhq_pkg::StIdle: begin
        if (in_fire) begin
          state_d = imhq_pkg::StResp;
          unique case (func_i)
            imhq_pkg::FuncInsert: begin
              if (ins_ok) state_d = imhq_pkg::StUpCheck;
            end
            imhq_pkg::FuncExtract: begin
              if (size_q != '0) state_d = imhq_pkg::StExTop;
            end
            imhq_pkg::FuncDecrease: begin
              if (dec_ok) state_d = imhq_pkg::StDecKey;
            end
            default: state_d = imhq_pkg::StResp;
          endcase
        end
      end
      imhq_pkg::StDecKey: state_d = dec_less ? imhq_pkg::StUpCheck : imhq_pkg::StResp;
      imhq_pkg::StExTop: state_d = imhq_pkg::StExLast;
      imhq_pkg::StExLast: state_d = (size_q == '0) ? imhq_pkg::StResp : imhq_pkg::StExKey;
      imhq_pkg::StExKey: state_d = imhq_pkg::StDnL;
      imhq_pkg::StUpCheck: state_d = (idx_q == '0) ? imhq_pkg::StPlace : imhq_pkg::StUpPar;
      imhq_pkg::StUpPar: state_d = imhq_pkg::StUpCmp;
      imhq_pkg::StUpCmp: state_d = up_move ? imhq_pkg::StUpCheck : imhq_pkg::StPlace;
      imhq_pkg::StDnL: state_d = (lpos < size_ext) ? imhq_pkg::StDnLid : imhq_pkg::StPlace;
      imhq_pkg::StDnLid: state_d = imhq_pkg::StDnLkey;
      imhq_pkg::StDnLkey: state_d = r_ok_q ? imhq_pkg::StDnRkey : imhq_pkg::StDnCmp;
      imhq_pkg::StDnRkey: state_d = imhq_pkg::StDnCmp;
      imhq_pkg::StDnCmp: begin
        state_d = (l_above || r_above) ? imhq_pkg::StDnL : imhq_pkg::StPlace;
      end
      imhq_pkg::StPlace: state_d = imhq_pkg::StResp;
      imhq_pkg::StResp: begin
        if (push) state_d = imhq_pkg::StIdle;
      end
      default: state_d = imhq_pkg::StIdle;
    endcase
  end

  always_comb begin
    size_d = size_q;
    cap_d = cap_q;
    valid_d = valid_q;
    idx_d = idx_q;
    jdx_d = jdx_q;
    cur_id_d = cur_id_q;
    cur_key_d = cur_key_q;
    oth_id_d = oth_id_q;
    oth_key_d = oth_key_q;
    rid_d = rid_q;
    rkey_d = rkey_q;
    r_ok_d = r_ok_q;
    top_d = top_q;
    res_status_d = res_status_q;
    res_flag_d = res_flag_q;
    res_top_d = res_top_q;
    out_status_d = out_status_q;
    out_item_d = out_item_q;
    out_flag_d = out_flag_q;
    out_count_d = out_count_q;
    out_valid_d = out_valid_q && !out_ready_i;
    heap_req_o = '0;
    item_req_o = '0;

    if (cfg_valid_i) begin
      cap_d = (capacity_in_use_i > CntW'(imhq_pkg::MaxItems))
          ? CntW'(imhq_pkg::MaxItems) : capacity_in_use_i;
    end

    unique case (state_q)
      imhq_pkg::StIdle: begin
        item_req_o.raddr = item_id_i;
        if (in_fire) begin
          cur_id_d = item_id_i;
          cur_key_d = $unsigned(key_value_i) ^ imhq_pkg::KeySign;
          res_status_d = imhq_pkg::StatusIgnored;
          res_flag_d = 1'b0;
          res_top_d = 1'b0;
          unique case (func_i)
            imhq_pkg::FuncInsert: begin
              if (ins_ok) begin
                idx_d = size_q[IdxW-1:0];
                size_d = size_q + CntW'(1);
                valid_d[item_id_i] = 1'b1;
              end
            end
            imhq_pkg::FuncExtract: begin
              if (size_q == '0) res_status_d = imhq_pkg::StatusEmpty;
            end
            imhq_pkg::FuncContains: begin
              res_status_d = imhq_pkg::StatusDone;
              res_flag_d = dec_ok;
            end
            imhq_pkg::FuncIsEmpty: begin
              res_status_d = imhq_pkg::StatusDone;
              res_flag_d = (size_q == '0);
            end
            default: res_status_d = res_status_d;
          endcase
        end
      end
      imhq_pkg::StDecKey: begin
        idx_d = item_rdata_i.pos;
      end
      imhq_pkg::StExTop: begin
        top_d = heap_rdata_i;
        valid_d[heap_rdata_i] = 1'b0;
        size_d = size_m1;
        heap_req_o.raddr = size_m1[IdxW-1:0];
        res_top_d = 1'b1;
        res_status_d = imhq_pkg::StatusDone;
      end
      imhq_pkg::StExLast: begin
        cur_id_d = heap_rdata_i;
        item_req_o.raddr = heap_rdata_i;
        idx_d = '0;
      end
      imhq_pkg::StExKey: begin
        cur_key_d = item_rdata_i.key;
      end
      imhq_pkg::StUpCheck: begin
        jdx_d = up_pos;
        heap_req_o.raddr = up_pos;
      end
      imhq_pkg::StUpPar: begin
        oth_id_d = heap_rdata_i;
        item_req_o.raddr = heap_rdata_i;
      end
      imhq_pkg::StUpCmp: begin
        if (up_move) begin
          heap_req_o.we = 1'b1;
          heap_req_o.waddr = idx_q;
          heap_req_o.wdata = oth_id_q;
          item_req_o.we = 1'b1;
          item_req_o.waddr = oth_id_q;
          item_req_o.wdata = '{key: item_rdata_i.key, pos: idx_q};
          idx_d = jdx_q;
        end
      end
      imhq_pkg::StDnL: begin
        heap_req_o.raddr = lpos[IdxW-1:0];
      end
      imhq_pkg::StDnLid: begin
        oth_id_d = heap_rdata_i;
        item_req_o.raddr = heap_rdata_i;
        r_ok_d = rpos < size_ext;
        heap_req_o.raddr = rpos[IdxW-1:0];
      end
      imhq_pkg::StDnLkey: begin
        oth_key_d = item_rdata_i.key;
        rid_d = heap_rdata_i;
        item_req_o.raddr = heap_rdata_i;
      end
      imhq_pkg::StDnRkey: begin
        rkey_d = item_rdata_i.key;
      end
      imhq_pkg::StDnCmp: begin
        if (l_above || r_above) begin
          heap_req_o.we = 1'b1;
          heap_req_o.waddr = idx_q;
          heap_req_o.wdata = best_id;
          item_req_o.we = 1'b1;
          item_req_o.waddr = best_id;
          item_req_o.wdata = '{key: best_key, pos: idx_q};
          idx_d = best_pos;
        end
      end
      imhq_pkg::StPlace: begin
        heap_req_o.we = 1'b1;
        heap_req_o.waddr = idx_q;
        heap_req_o.wdata = cur_id_q;
        item_req_o.we = 1'b1;
        item_req_o.waddr = cur_id_q;
        item_req_o.wdata = '{key: cur_key_q, pos: idx_q};
        res_status_d = imhq_pkg::StatusDone;
      end
      imhq_pkg::StResp: begin
        if (push) begin
          out_valid_d = 1'b1;
          out_status_d = res_status_q;
          out_item_d = res_top_q ? CntW'(top_q) : cap_q;
          out_flag_d = res_flag_q;
          out_count_d = size_q;
        end
      end
      default: out_valid_d = out_valid_d;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= imhq_pkg::StIdle;
      size_q <= '0;
      cap_q <= CntW'(imhq_pkg::MaxItems);
      valid_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      size_q <= size_d;
      cap_q <= cap_d;
      valid_q <= valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    jdx_q <= jdx_d;
    cur_id_q <= cur_id_d;
    cur_key_q <= cur_key_d;
    oth_id_q <= oth_id_d;
    oth_key_q <= oth_key_d;
    rid_q <= rid_d;
    rkey_q <= rkey_d;
    r_ok_q <= r_ok_d;
    top_q <= top_d;
    res_status_q <= res_status_d;
    res_flag_q <= res_flag_d;
    res_top_q <= res_top_d;
    out_status_q <= out_status_d;
    out_item_q <= out_item_d;
    out_flag_q <= out_flag_d;
    out_count_q <= out_count_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o = out_status_q;
  assign out_item_o = out_item_q;
  assign answer_flag_o = out_flag_q;
  assign item_count_o = out_count_q;

  `IMHQ_ASSERT_IMPL(a_size_bound, 1'b1, size_q <= CntW'(imhq_pkg::MaxItems))
  `IMHQ_ASSERT_IMPL(a_sift_in_heap,
      (state_q == imhq_pkg::StUpCheck) || (state_q == imhq_pkg::StDnL),
      CntW'(idx_q) < size_q)
  `IMHQ_ASSERT_NEXT(a_empty_extract,
      in_fire && (func_i == imhq_pkg::FuncExtract) && (size_q == '0),
      state_q == imhq_pkg::StResp)
  `IMHQ_ASSERT_IMPL(a_empty_count,
      out_valid_q && (out_status_q == imhq_pkg::StatusEmpty),
      out_count_q == '0)

endmodule

### rtl/indexed_min_heap_queue.sv
// Top level of the indexed min-heap priority queue.
// One request is handled at a time, and every request gives one result. Contains, is-empty
// and requests rejected on decode go straight to the result step; a decrease whose key is
// not smaller first reads the item's stored key and position. Insert places the item in the
// last slot and lets it climb while it ranks above its parent; decrease key does the same
// from the item's current slot. Extract takes the top item and, unless that empties the
// queue, moves the last item to the root and lets it sink while a child ranks above it.
// Each step waits on the single registered read port of the heap slot memory and of the
// per-item key and position memory. The next request is taken as soon as the result
// sits in the output register, even if it has not been collected yet.
module indexed_min_heap_queue (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [imhq_pkg::FuncW-1:0]        func_i,
  input  logic [imhq_pkg::IdxW-1:0]         item_id_i,
  input  logic signed [imhq_pkg::KeyW-1:0]  key_value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [imhq_pkg::StatusW-1:0]      status_o,
  output logic [imhq_pkg::CntW-1:0]         out_item_o,
  output logic                              answer_flag_o,
  output logic [imhq_pkg::CntW-1:0]         item_count_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [imhq_pkg::CntW-1:0]         capacity_in_use_i
);

  imhq_pkg::heap_req_t heap_req;
  logic [imhq_pkg::IdxW-1:0] heap_rdata;
  imhq_pkg::item_req_t item_req;
  imhq_pkg::item_word_t item_rdata;

  imhq_ctrl u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .func_i            (func_i),
    .item_id_i         (item_id_i),
    .key_value_i       (key_value_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .status_o          (status_o),
    .out_item_o        (out_item_o),
    .answer_flag_o     (answer_flag_o),
    .item_count_o      (item_count_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .capacity_in_use_i (capacity_in_use_i),
    .heap_req_o        (heap_req),
    .heap_rdata_i      (heap_rdata),
    .item_req_o        (item_req),
    .item_rdata_i      (item_rdata)
  );

  imhq_heap_mem u_heap_mem (
    .clk_i   (clk_i),
    .req_i   (heap_req),
    .rdata_o (heap_rdata)
  );

  imhq_item_mem u_item_mem (
    .clk_i   (clk_i),
    .req_i   (item_req),
    .rdata_o (item_rdata)
  );

endmodule
